// File: src/int_to_decimal_ascii_assert.svh
// Assertion macros for the decimal text converter.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define I2DA_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("i2da assertion failed");

// Check that cond implies prop in the next cycle.
`define I2DA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("i2da assertion failed");

`endif

// File: src/i2da_pkg.sv
// Shared types, constants and the shift-add-3 step for the decimal text converter.
package i2da_pkg;

   localparam int WORD_W    = 32;
   localparam int DIGITS    = 10;
   localparam int BCD_W     = 4 * DIGITS;
   localparam int STAGES    = 8;
   localparam int STEPS     = WORD_W / STAGES;
   localparam int COUNT_W   = 4;
   localparam int CHAR_W    = 8;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_DASH = 8'h2D;

   typedef struct packed {
      logic              neg;
      logic [BCD_W-1:0]  bcd;
      logic [WORD_W-1:0] bin;
   } item_type;

   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                    input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int k = 0; k < DIGITS; k++) begin
         if (adj[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

// File: src/int_to_decimal_ascii.sv
// Top level of the 32-bit binary to decimal ASCII text converter.
//
// Input channel req_: one beat carries a 32-bit word in req_tdata and the
// signed-mode flag in req_tuser. Result channel rsp_: one beat per ASCII
// character, most significant digit first, a leading '-' for a negative word
// in signed mode. rsp_tlast marks the final character of a number, and that
// beat carries the character count (1 to 11) in rsp_tdata[11:8]; other beats
// carry zero there.
// Each input word is made a magnitude and registered, then passes the eight
// shift-add-3 stages of four steps each and is loaded into the emitter.
// Throughput: the emitter sends one character per cycle while rsp_tready is
// high; a number has 1 to 11 characters, and while it drains, up to nine more
// words are taken into the pipeline.
// Reset clears all valid bits and the emitter; no beat is in flight after it.
// When the receiver holds rsp_tready low, the current beat holds and the
// pipeline stalls stage by stage; nothing is dropped or repeated.
`include "int_to_decimal_ascii_assert.svh"

module int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] is_signed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] character, [11:8] char_count, [15:12] zero
   output logic        rsp_tlast
);

   logic                                  s0_valid_ff;
   i2da_pkg::item_type                    s0_item_ff;
   i2da_pkg::item_type                    s0_item_in;
   logic                                  negative;

   logic               st_valid [i2da_pkg::STAGES+1];
   logic               st_ready [i2da_pkg::STAGES+1];
   i2da_pkg::item_type st_item   [i2da_pkg::STAGES+1];

   logic [i2da_pkg::CHAR_W-1:0]  character;
   logic [i2da_pkg::COUNT_W-1:0] char_count;

   assign negative       = req_tuser && req_tdata[i2da_pkg::WORD_W-1];
   assign s0_item_in.neg = negative;
   assign s0_item_in.bcd = '0;
   assign s0_item_in.bin = negative ? (32'd0 - req_tdata) : req_tdata;

   assign req_tready  = !s0_valid_ff || st_ready[0];
   assign st_valid[0] = s0_valid_ff;
   assign st_item[0]  = s0_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_item_ff <= s0_item_in;
      end
   end

   for (genvar g = 0; g < i2da_pkg::STAGES; g++) begin : g_stage
      i2da_dabble u_dabble (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (st_valid[g]),
         .up_ready   (st_ready[g]),
         .up_item    (st_item[g]),
         .down_valid (st_valid[g+1]),
         .down_ready (st_ready[g+1]),
         .down_item  (st_item[g+1])
      );
   end

   i2da_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (st_valid[i2da_pkg::STAGES]),
      .up_ready  (st_ready[i2da_pkg::STAGES]),
      .up_item   (st_item[i2da_pkg::STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (character),
      .out_last  (rsp_tlast),
      .out_count (char_count)
   );

   assign rsp_tdata = {4'b0000, char_count, character};

   `I2DA_ASSERT_SAME(a_count_range, clock, reset, rsp_tvalid && rsp_tlast,
                     (char_count != 4'd0) && (char_count <= 4'd11))
   `I2DA_ASSERT_SAME(a_count_only_last, clock, reset, rsp_tvalid && !rsp_tlast,
                     char_count == 4'd0)
   `I2DA_ASSERT_SAME(a_dash_not_last, clock, reset,
                     rsp_tvalid && (character == i2da_pkg::ASCII_DASH), !rsp_tlast)
   `I2DA_ASSERT_NEXT(a_dash_then_digit, clock, reset,
                     rsp_tvalid && rsp_tready && (character == i2da_pkg::ASCII_DASH),
                     rsp_tvalid && (character != i2da_pkg::ASCII_DASH))

endmodule

// File: src/i2da_dabble.sv
// One pipeline stage of the binary to BCD conversion: several shift-add-3 steps.
module i2da_dabble (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  i2da_pkg::item_type up_item,
   output logic               down_valid,
   input  logic               down_ready,
   output i2da_pkg::item_type down_item
);

   logic               valid_ff;
   i2da_pkg::item_type item_ff;
   i2da_pkg::item_type item_in;

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_item  = item_ff;

   always_comb begin
      item_in = up_item;
      for (int s = 0; s < i2da_pkg::STEPS; s++) begin
         item_in.bcd = i2da_pkg::dabble_step(item_in.bcd, item_in.bin[i2da_pkg::WORD_W-1]);
         item_in.bin = {item_in.bin[i2da_pkg::WORD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: src/i2da_emit.sv
// Character emitter: walks the BCD digits of one number and drives the result beats.
module i2da_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  i2da_pkg::item_type                  up_item,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [i2da_pkg::CHAR_W-1:0]         out_char,
   output logic                                out_last,
   output logic [i2da_pkg::COUNT_W-1:0]        out_count
);

   logic                              busy_ff;
   logic                              busy_in;
   logic                              neg_ff;
   logic [i2da_pkg::BCD_W-1:0]        bcd_ff;
   logic [i2da_pkg::COUNT_W-1:0]      ndig_ff;
   logic [i2da_pkg::COUNT_W-1:0]      ndig_in;
   logic [i2da_pkg::COUNT_W-1:0]      pos_ff;
   logic [i2da_pkg::COUNT_W-1:0]      pos_in;
   logic [i2da_pkg::COUNT_W-1:0]      total;
   logic [i2da_pkg::COUNT_W-1:0]      idx;
   logic [i2da_pkg::BCD_W-1:0]        shifted;
   logic                              is_dash;
   logic                              load;
   logic                              beat;

   assign total    = ndig_ff + {{(i2da_pkg::COUNT_W-1){1'b0}}, neg_ff};
   assign is_dash  = neg_ff && (pos_ff == '0);
   assign idx      = ndig_ff - 4'd1 - (pos_ff - {{(i2da_pkg::COUNT_W-1){1'b0}}, neg_ff});
   assign shifted  = bcd_ff >> {idx, 2'b00};
   assign out_valid = busy_ff;
   assign out_last  = (pos_ff == total - 4'd1);
   assign out_count = out_last ? total : '0;
   assign out_char  = is_dash ? i2da_pkg::ASCII_DASH
                              : (i2da_pkg::ASCII_ZERO | {4'b0000, shifted[3:0]});

   assign beat     = busy_ff && out_ready;
   assign up_ready = !busy_ff || (out_ready && out_last);
   assign load     = up_valid && up_ready;

   always_comb begin
      ndig_in = 4'd1;
      for (int k = 1; k < i2da_pkg::DIGITS; k++) begin
         if (up_item.bcd[4*k +: 4] != 4'd0) begin
            ndig_in = i2da_pkg::COUNT_W'(k + 1);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      priority if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (beat) begin
         busy_in = !out_last;
         pos_in  = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff  <= up_item.neg;
         bcd_ff  <= up_item.bcd;
         ndig_ff <= ndig_in;
      end
   end

endmodule
